[design/ukmv_pkg.sv]
// ----------------------------------------------------------------------------
// ukmv_pkg
// Shared types and fixed widths for the unbounded knapsack (rod cutting) block.
// ----------------------------------------------------------------------------
package ukmv_pkg;

	localparam int LEN_W   = 8;
	localparam int PRICE_W = 16;
	localparam int VALUE_W = 24;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SWEEP,
		ST_READ,
		ST_OUT
	} ukmv_state_t;

	typedef struct packed {
		logic load_item;
		logic issue;
		logic read_out;
		logic load_out;
	} ukmv_cmd_t;

	typedef struct packed {
		logic sweep_ok;
		logic at_cap;
		logic last;
		logic out_free;
	} ukmv_sts_t;

endpackage

[design/ukmv_ctrl.sv]
// ----------------------------------------------------------------------------
// ukmv_ctrl
// Sequencer: takes a piece, runs the table sweep, reads and hands out the result.
// ----------------------------------------------------------------------------
module ukmv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               piece_valid,
	output logic               piece_ready,
	input  ukmv_pkg::ukmv_sts_t sts,
	output ukmv_pkg::ukmv_cmd_t cmd
);

	ukmv_pkg::ukmv_state_t state_q;
	ukmv_pkg::ukmv_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ukmv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		piece_ready   = 1'b0;
		cmd           = '0;
		case (state_q)
			ukmv_pkg::ST_IDLE: begin
				piece_ready = 1'b1;
				if (piece_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ukmv_pkg::ST_CHECK;
				end
			end
			ukmv_pkg::ST_CHECK: begin
				if (sts.sweep_ok) begin
					state_d = ukmv_pkg::ST_SWEEP;
				end else if (sts.last) begin
					state_d = ukmv_pkg::ST_READ;
				end else begin
					state_d = ukmv_pkg::ST_IDLE;
				end
			end
			ukmv_pkg::ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (sts.at_cap) begin
					state_d = sts.last ? ukmv_pkg::ST_READ : ukmv_pkg::ST_IDLE;
				end
			end
			ukmv_pkg::ST_READ: begin
				cmd.read_out = 1'b1;
				state_d      = ukmv_pkg::ST_OUT;
			end
			ukmv_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ukmv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ukmv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/ukmv_dp.sv]
// ----------------------------------------------------------------------------
// ukmv_dp
// Datapath: best-value table with two registered read ports, the update stage,
// the rod length register and the result register.
// ----------------------------------------------------------------------------
module ukmv_dp #(
	parameter int MAX_ROD    = 255,
	parameter int PRICE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [ukmv_pkg::LEN_W-1:0]          rod_length,
	input  logic [ukmv_pkg::LEN_W-1:0]          piece_length,
	input  logic [ukmv_pkg::PRICE_W-1:0]        piece_price,
	input  logic                                last_piece,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [ukmv_pkg::VALUE_W-1:0]        max_value,
	input  ukmv_pkg::ukmv_cmd_t                 cmd,
	output ukmv_pkg::ukmv_sts_t                 sts
);

	localparam int LW      = ukmv_pkg::LEN_W;
	localparam int PW      = ukmv_pkg::PRICE_W;
	localparam int VW      = ukmv_pkg::VALUE_W;
	localparam int CAP_MAX = (MAX_ROD < 255) ? MAX_ROD : 255;
	localparam int DEPTH   = CAP_MAX + 1;
	localparam int AW      = $clog2(DEPTH);
	localparam logic [PW-1:0] PRICE_MASK =
		(PRICE_BITS >= PW) ? {PW{1'b1}} : PW'((32'd1 << PRICE_BITS) - 32'd1);

	logic [VW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [LW-1:0] rod_q;
	logic [LW-1:0] len_q;
	logic [PW-1:0] price_q;
	logic          last_q;
	logic [AW-1:0] cap_q;
	logic [AW-1:0] cap_d;
	logic [AW-1:0] j_q;

	logic [AW-1:0] rd_a_addr;
	logic [AW-1:0] rd_b_addr;
	logic          rd_en;

	logic          v_s1;
	logic [AW-1:0] j_s1;
	logic [VW-1:0] ra_s1;
	logic [VW-1:0] rb_s1;
	logic          vld_a_s1;
	logic          vld_b_s1;
	logic          fwd_a_s1;
	logic          fwd_b_s1;
	logic [VW-1:0] wdat_q;

	logic [VW-1:0] a_val;
	logic [VW-1:0] b_val;
	logic [VW:0]   sum;
	logic [VW-1:0] cand;
	logic [VW-1:0] wdata;

	logic          out_valid_q;
	logic [VW-1:0] out_q;

	assign cap_d = (32'(rod_q) > CAP_MAX) ? AW'(CAP_MAX) : AW'(rod_q);

	assign rd_en     = cmd.issue | cmd.read_out;
	assign rd_a_addr = cmd.read_out ? cap_q : j_q;
	assign rd_b_addr = j_q - len_q[AW-1:0];

	assign a_val = fwd_a_s1 ? wdat_q : (vld_a_s1 ? ra_s1 : '0);
	assign b_val = fwd_b_s1 ? wdat_q : (vld_b_s1 ? rb_s1 : '0);
	assign sum   = (VW+1)'(price_q) + {1'b0, b_val};
	assign cand  = sum[VW] ? ukmv_pkg::VALUE_MAX : sum[VW-1:0];
	assign wdata = (cand > a_val) ? cand : a_val;

	assign sts.sweep_ok = (len_q != '0) && (len_q <= LW'(cap_q));
	assign sts.at_cap   = (j_q == cap_q);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign max_value    = out_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[j_s1] <= wdata;
			wdat_q    <= wdata;
		end
		if (rd_en) begin
			ra_s1    <= mem[rd_a_addr];
			rb_s1    <= mem[rd_b_addr];
			vld_a_s1 <= vld_q[rd_a_addr];
			vld_b_s1 <= vld_q[rd_b_addr];
			fwd_a_s1 <= v_s1 && (j_s1 == rd_a_addr);
			fwd_b_s1 <= v_s1 && (j_s1 == rd_b_addr);
		end
		if (cmd.issue) begin
			j_s1 <= j_q;
		end
		if (cmd.load_item) begin
			len_q   <= piece_length;
			price_q <= piece_price & PRICE_MASK;
			last_q  <= last_piece;
			cap_q   <= cap_d;
		end
		if (cmd.load_out) begin
			out_q <= a_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rod_q       <= '0;
			vld_q       <= '0;
			v_s1        <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				rod_q <= rod_length;
			end
			v_s1 <= cmd.issue;
			if (cmd.load_out) begin
				vld_q <= '0;
			end else if (v_s1) begin
				vld_q[j_s1] <= 1'b1;
			end
			if (cmd.load_item) begin
				j_q <= piece_length[AW-1:0];
			end else if (cmd.issue) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/unbounded_knapsack_max_value.sv]
// ----------------------------------------------------------------------------
// unbounded_knapsack_max_value
// Rod cutting evaluator: folds piece kinds into a best-value table and reports
// the best value for the configured rod length after the last piece.
// ----------------------------------------------------------------------------
// Channel   Signals                                          Direction
// piece     piece_valid/ready, piece_length, piece_price,    in
//           last_piece
// result    result_valid/ready, max_value                    out
// cfg       cfg_valid/ready, rod_length                      in
//
// A piece of length zero or longer than cap skips the sweep; otherwise the sweep
// visits entries piece_length to cap, one table entry per cycle through the
// single write port of the table. A last piece then reads out the result.
// The result register lets the next piece start while a result waits; a last
// piece then holds until that beat is taken. Reset clears the table at once.
// ----------------------------------------------------------------------------
module unbounded_knapsack_max_value #(
	parameter int MAX_ROD    = 255,
	parameter int PRICE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ukmv_pkg::LEN_W-1:0]   rod_length,
	input  logic                         piece_valid,
	output logic                         piece_ready,
	input  logic [ukmv_pkg::LEN_W-1:0]   piece_length,
	input  logic [ukmv_pkg::PRICE_W-1:0] piece_price,
	input  logic                         last_piece,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [ukmv_pkg::VALUE_W-1:0] max_value
);

	ukmv_pkg::ukmv_cmd_t cmd;
	ukmv_pkg::ukmv_sts_t sts;

	assign cfg_ready = 1'b1;

	ukmv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.piece_valid (piece_valid),
		.piece_ready (piece_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	ukmv_dp #(
		.MAX_ROD    (MAX_ROD),
		.PRICE_BITS (PRICE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.rod_length   (rod_length),
		.piece_length (piece_length),
		.piece_price  (piece_price),
		.last_piece   (last_piece),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.max_value    (max_value),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

[design/ukmv_checker.sv]
// ----------------------------------------------------------------------------
// ukmv_checker
// Port-level checks of the rod cutting evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module ukmv_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_ready,
	input logic                         piece_valid,
	input logic                         piece_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [ukmv_pkg::VALUE_W-1:0] max_value
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(max_value))
		else $error("result beat dropped or changed while stalled");

	a_busy_after_piece: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece_ready |=> !piece_ready)
		else $error("piece accepted while the previous one is still being folded");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!piece_ready))
		else $error("result appeared without a finished sweep");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind unbounded_knapsack_max_value ukmv_checker u_ukmv_checker (.*);

[bench/tb_unbounded_knapsack_max_value.sv]
// ----------------------------------------------------------------------------
// tb_unbounded_knapsack_max_value
// Self-checking bench for the rod cutting evaluator. A queue of piece kinds
// feeds a valid/ready driver and each accepted beat is folded into a local
// best-value table. Every last piece yields one expected max_value, which the
// monitor compares with the result channel. The bench runs directed problems
// and then random problems over many rod lengths, with random gaps on both
// sides and rod length changes made in the middle of open problems.
// ----------------------------------------------------------------------------
module tb_unbounded_knapsack_max_value;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB_MAX_ROD    = 255;
	localparam int SETTLE_CYCLES = 300;
	localparam int PHASES        = 24;
	localparam int PER_PHASE     = 65;
	localparam longint LIMIT     = 4_000_000;

	typedef struct packed {
		logic [ukmv_pkg::LEN_W-1:0]   len;
		logic [ukmv_pkg::PRICE_W-1:0] price;
		logic                         last;
	} piece_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         cfg_valid    = 1'b0;
	logic                         cfg_ready;
	logic [ukmv_pkg::LEN_W-1:0]   rod_length   = '0;
	logic                         piece_valid  = 1'b0;
	logic                         piece_ready;
	logic [ukmv_pkg::LEN_W-1:0]   piece_length = '0;
	logic [ukmv_pkg::PRICE_W-1:0] piece_price  = '0;
	logic                         last_piece   = 1'b0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic [ukmv_pkg::VALUE_W-1:0] max_value;

	piece_t                       pieces_to_send[$];
	logic [ukmv_pkg::VALUE_W-1:0] expected_max_values[$];
	piece_t                       on_wire;
	logic [ukmv_pkg::VALUE_W-1:0] best_table [0:TB_MAX_ROD];
	logic [ukmv_pkg::LEN_W-1:0]   rod_setting = '0;
	int                           send_idle_pct = 37;
	int                           recv_idle_pct = 37;
	int                           pieces_accepted = 0;
	int                           values_checked = 0;
	int                           value_errors = 0;
	int                           rod_writes = 0;
	longint                       cycle_count = 0;

	unbounded_knapsack_max_value dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.rod_length   (rod_length),
		.piece_valid  (piece_valid),
		.piece_ready  (piece_ready),
		.piece_length (piece_length),
		.piece_price  (piece_price),
		.last_piece   (last_piece),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.max_value    (max_value)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i <= TB_MAX_ROD; i++) begin
			best_table[i] = '0;
		end
	end

	// Folds one piece kind into the table; a last piece yields the expected value.
	function automatic void fold_piece_kind(input piece_t p);
		int cap;
		logic [ukmv_pkg::VALUE_W:0] cand;
		cap = (int'(rod_setting) > TB_MAX_ROD) ? TB_MAX_ROD : int'(rod_setting);
		if (p.len != 0 && int'(p.len) <= cap) begin
			for (int j = int'(p.len); j <= cap; j++) begin
				cand = {1'b0, best_table[j - int'(p.len)]} + p.price;
				if (cand > {1'b0, ukmv_pkg::VALUE_MAX}) begin
					cand = {1'b0, ukmv_pkg::VALUE_MAX};
				end
				if (cand[ukmv_pkg::VALUE_W-1:0] > best_table[j]) begin
					best_table[j] = cand[ukmv_pkg::VALUE_W-1:0];
				end
			end
		end
		if (p.last) begin
			expected_max_values.push_back(best_table[cap]);
			for (int i = 0; i <= TB_MAX_ROD; i++) begin
				best_table[i] = '0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_valid <= 1'b0;
		end else begin
			if (piece_valid && piece_ready) begin
				fold_piece_kind(on_wire);
				pieces_accepted++;
			end
			if (!piece_valid || piece_ready) begin
				if (pieces_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = pieces_to_send.pop_front();
					piece_valid  <= 1'b1;
					piece_length <= on_wire.len;
					piece_price  <= on_wire.price;
					last_piece   <= on_wire.last;
				end else begin
					piece_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [ukmv_pkg::VALUE_W-1:0] want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_max_values.size() == 0) begin
					$error("max_value: expected none, actual %0d", max_value);
					value_errors++;
				end else begin
					want = expected_max_values.pop_front();
					if (max_value !== want) begin
						$error("max_value: expected %0d, actual %0d", want, max_value);
						value_errors++;
					end
				end
				values_checked++;
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("unbounded_knapsack_max_value regression: fail");
			$finish;
		end
	end

	task automatic push_piece(input int len, input int price, input bit last);
		piece_t p;
		p.len   = ukmv_pkg::LEN_W'(len);
		p.price = ukmv_pkg::PRICE_W'(price);
		p.last  = last;
		pieces_to_send.push_back(p);
	endtask

	// Holds the sender until every beat is out and every expected value is back.
	task automatic drain_all();
		@(negedge clk);
		while (pieces_to_send.size() != 0 || piece_valid || expected_max_values.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_rod(input int value);
		@(posedge clk);
		cfg_valid  <= 1'b1;
		rod_length <= ukmv_pkg::LEN_W'(value);
		do begin
			@(posedge clk);
		end while (!(cfg_valid && cfg_ready));
		cfg_valid   <= 1'b0;
		rod_setting = ukmv_pkg::LEN_W'(value);
		rod_writes++;
	endtask

	task automatic queue_problem(input int cap, input bit close_it, inout int counted);
		int n;
		int r;
		piece_t p;
		n = $urandom_range(6, 1);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				p.len = '0;
			end else if (r < 16 && cap < TB_MAX_ROD) begin
				p.len = ukmv_pkg::LEN_W'($urandom_range(255, cap + 1));
			end else if (cap == 0) begin
				p.len = ukmv_pkg::LEN_W'($urandom_range(255));
			end else begin
				p.len = ukmv_pkg::LEN_W'($urandom_range(cap, 1));
			end
			r = $urandom_range(99);
			if (r < 25) begin
				p.price = ukmv_pkg::PRICE_W'($urandom);
			end else if (r < 30) begin
				p.price = '1;
			end else if (r < 33) begin
				p.price = '0;
			end else begin
				p.price = ukmv_pkg::PRICE_W'($urandom_range(200));
			end
			p.last = (close_it && k == n - 1) || ($urandom_range(99) < 3);
			if (p.last || (p.len != 0 && int'(p.len) <= cap)) begin
				counted++;
			end
			pieces_to_send.push_back(p);
		end
	endtask

	initial begin
		int cap;
		int counted;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_rod(255);
		push_piece(1, 65535, 1);
		push_piece(255, 65535, 1);
		push_piece(0, 65535, 1);
		push_piece(255, 0, 0);
		push_piece(128, 100, 0);
		push_piece(127, 1, 1);
		drain_all();

		write_rod(0);
		push_piece(1, 7, 1);
		push_piece(0, 9, 1);
		drain_all();

		write_rod(8);
		push_piece(1, 1, 0);
		push_piece(2, 5, 0);
		push_piece(3, 8, 0);
		push_piece(4, 9, 0);
		push_piece(9, 1000, 0);
		push_piece(0, 500, 0);
		push_piece(5, 10, 0);
		push_piece(6, 17, 0);
		push_piece(7, 17, 0);
		push_piece(8, 20, 1);
		drain_all();

		// The rod grows while a problem is still open.
		write_rod(4);
		push_piece(2, 3, 0);
		push_piece(3, 7, 0);
		drain_all();
		write_rod(10);
		push_piece(5, 6, 1);
		drain_all();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 5 || ph == 17) begin
				cap = 255;
			end else if (ph == 11) begin
				cap = 0;
			end else if (ph == 20 || ph == 22) begin
				cap = $urandom_range(255);
			end else begin
				cap = $urandom_range(40, 1);
			end
			send_idle_pct = (ph >= 8 && ph <= 10) ? 0 : 37;
			recv_idle_pct = send_idle_pct;
			write_rod(cap);
			counted = 0;
			while (counted < PER_PHASE) begin
				queue_problem(cap, 1'b1, counted);
			end
			if (ph % 4 == 3 && ph != PHASES - 1) begin
				queue_problem(cap, 1'b0, counted);
			end
			if (ph == PHASES - 1) begin
				push_piece(0, 0, 1);
			end
			drain_all();
		end

		$display("Covered %0d piece beats and %0d max_value beats over %0d rod settings,",
			pieces_accepted, values_checked, rod_writes);
		$display("including empty rods, full-length rods and rods changed mid-problem.");
		if (value_errors == 0) begin
			$display("unbounded_knapsack_max_value regression: pass");
		end else begin
			$display("unbounded_knapsack_max_value regression: fail");
		end
		$finish;
	end

endmodule
